// ===== rtl/core/mrht_pkg.sv =====
// ----------------------------------------------------------------------------
// mrht_pkg
// Shared sizes, codes and control/status bundles of the meter reading history
// table.
// ----------------------------------------------------------------------------
package mrht_pkg;

    localparam int NODE_DEPTH = 32;
    localparam int SLOT_DEPTH = 128;
    localparam int NODE_W     = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
    localparam int SLOT_W     = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int MEM_AW     = NODE_W + SLOT_W;
    localparam int MEM_DEPTH  = 1 << MEM_AW;
    localparam int CNT_W      = (MEM_AW > 5) ? MEM_AW : 5;

    localparam int INTERVAL_W = 11;
    localparam int DVS_W      = 17;
    localparam int AGE_W      = 32;

    localparam logic [31:0] EMPTY_VALUE = 32'h0000_FFFF;
    localparam int          SEC_PER_MIN = 60;

    // register indexes
    localparam logic REG_INTERVAL = 1'b0;
    localparam logic REG_GATE     = 1'b1;

    // opcodes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_REPORT    = 3'd1;
    localparam logic [2:0] OP_READ_ADDR = 3'd2;
    localparam logic [2:0] OP_READ_MAC  = 3'd3;
    localparam logic [2:0] OP_HISTORY   = 3'd4;

    // result codes
    localparam logic [2:0] RC_OK        = 3'd0;
    localparam logic [2:0] RC_NOT_FOUND = 3'd1;
    localparam logic [2:0] RC_FULL      = 3'd2;
    localparam logic [2:0] RC_TOO_OLD   = 3'd3;
    localparam logic [2:0] RC_IGNORED   = 3'd4;

    // where the payload of a result comes from
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_IDX  = 2'd1,
        SRC_MEM  = 2'd2,
        SRC_REP  = 2'd3
    } t_src;

    typedef struct packed {
        logic       load;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       clear_wr;
        logic       tick_adv;
        logic       tick_wr;
        logic       scan;
        logic       node_set;
        logic       div_step;
        logic       rep_wr;
        logic       rd_issue;
        logic       rd_prev;
        logic       res_load;
        logic [2:0] res_code;
        t_src       res_src;
        logic       out_push;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       gate;
        logic       addr_zero;
        logic       clr_last;
        logic       scan_last;
        logic       div_last;
        logic       found_addr;
        logic       found_mac;
        logic       found_free;
        logic       too_old;
        logic       rd_empty;
    } t_status;

endpackage

// ===== rtl/core/meter_reading_history_table.sv =====
// Sequence: decode, then a tick walk over all nodes, or a 32-entry node scan
//   and the slot access (history reads run a 32-step divider in between); a
//   failed node lookup or an ignored item goes on to the output register.
// Flow: one transfer at a time; the next item is taken once the result
//   sits in the output register.
// Reset: synchronous, active low; a sweep then marks all 4096 slots empty
//   while the input stays stalled. Configuration writes are taken in every state.
// ----------------------------------------------------------------------------
// meter_reading_history_table
// Node table of meters with a ring of timed reading slots per node and a shared slot pointer.
// ----------------------------------------------------------------------------
//
// The controller walks the node table one entry a cycle, so every lookup
// and report costs a full scan; lowest match wins. Ticks, while the gate is set,
// advance the shared slot pointer and then write the empty marker into that slot
// for every node, again one node a cycle. History reads divide the age by
// interval * 60 with a one-bit-per-cycle restoring divider before the slot read.
// Slot storage is two memories (value; unit and status) with one write port
// and one registered read port each. A finished result moves into the output
// register, which holds it under stall while the next input transfer is accepted.
module meter_reading_history_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_wdata,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_node_addr,
    input  logic [55:0] i_node_mac,
    input  logic [31:0] i_reading_value,
    input  logic [7:0]  i_reading_unit,
    input  logic [7:0]  i_reading_status,
    input  logic [31:0] i_age_seconds,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_result_code,
    output logic [4:0]  o_entry_index,
    output logic [31:0] o_out_value,
    output logic [7:0]  o_out_unit,
    output logic [7:0]  o_out_status
);

    // command and status bundles between sequencer and datapath
    mrht_pkg::t_cmd    cmd;
    mrht_pkg::t_status st;

    mrht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    mrht_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_opcode         (i_opcode),
        .i_node_addr      (i_node_addr),
        .i_node_mac       (i_node_mac),
        .i_reading_value  (i_reading_value),
        .i_reading_unit   (i_reading_unit),
        .i_reading_status (i_reading_status),
        .i_age_seconds    (i_age_seconds),
        .i_cmd            (cmd),
        .o_st             (st),
        .o_result_code    (o_result_code),
        .o_entry_index    (o_entry_index),
        .o_out_value      (o_out_value),
        .o_out_unit       (o_out_unit),
        .o_out_status     (o_out_status)
    );

endmodule

// ===== rtl/core/mrht_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrht_ctrl
// Sequencer: reset sweep, decode, node scan, division, slot access, output.
// ----------------------------------------------------------------------------
module mrht_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  mrht_pkg::t_status i_st,
    output mrht_pkg::t_cmd    o_cmd
);

    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00_0000_0000_0001,
        S_IDLE   = 14'b00_0000_0000_0010,
        S_DEC    = 14'b00_0000_0000_0100,
        S_TICK   = 14'b00_0000_0000_1000,
        S_SCAN   = 14'b00_0000_0001_0000,
        S_SEL    = 14'b00_0000_0010_0000,
        S_WR     = 14'b00_0000_0100_0000,
        S_DIV    = 14'b00_0000_1000_0000,
        S_DIVCHK = 14'b00_0001_0000_0000,
        S_RD     = 14'b00_0010_0000_0000,
        S_RDW    = 14'b00_0100_0000_0000,
        S_RD2    = 14'b00_1000_0000_0000,
        S_RDW2   = 14'b01_0000_0000_0000,
        S_OUT    = 14'b10_0000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.res_src = mrht_pkg::SRC_NONE;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                priority if (i_st.op == mrht_pkg::OP_TICK) begin
                    if (i_st.gate) begin
                        o_cmd.tick_adv = 1'b1;
                        n_state        = S_TICK;
                    end else begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_code = mrht_pkg::RC_IGNORED;
                        n_state        = S_OUT;
                    end
                end else if ((i_st.op == mrht_pkg::OP_REPORT && i_st.addr_zero) ||
                             i_st.op > mrht_pkg::OP_HISTORY) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = mrht_pkg::RC_IGNORED;
                    n_state        = S_OUT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_TICK: begin
                o_cmd.tick_wr = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_st.scan_last) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = mrht_pkg::RC_OK;
                    n_state        = S_OUT;
                end
            end
            S_SCAN: begin
                o_cmd.scan    = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_st.scan_last) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                o_cmd.cnt_clr = 1'b1;
                unique case (i_st.op)
                    mrht_pkg::OP_REPORT: begin
                        if (i_st.found_addr || i_st.found_free) begin
                            o_cmd.node_set = 1'b1;
                            n_state        = S_WR;
                        end else begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_code = mrht_pkg::RC_FULL;
                            n_state        = S_OUT;
                        end
                    end
                    mrht_pkg::OP_READ_MAC: begin
                        if (i_st.found_mac) begin
                            o_cmd.node_set = 1'b1;
                            n_state        = S_RD;
                        end else begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_code = mrht_pkg::RC_NOT_FOUND;
                            n_state        = S_OUT;
                        end
                    end
                    default: begin
                        // read by address and history read
                        if (i_st.found_addr) begin
                            o_cmd.node_set = 1'b1;
                            n_state = (i_st.op == mrht_pkg::OP_HISTORY) ? S_DIV : S_RD;
                        end else begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_code = mrht_pkg::RC_NOT_FOUND;
                            n_state        = S_OUT;
                        end
                    end
                endcase
            end
            S_WR: begin
                o_cmd.rep_wr   = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_code = mrht_pkg::RC_OK;
                o_cmd.res_src  = mrht_pkg::SRC_REP;
                n_state        = S_OUT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                if (i_st.div_last) begin
                    n_state = S_DIVCHK;
                end
            end
            S_DIVCHK: begin
                if (i_st.too_old) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = mrht_pkg::RC_TOO_OLD;
                    o_cmd.res_src  = mrht_pkg::SRC_IDX;
                    n_state        = S_OUT;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RDW;
            end
            S_RDW: begin
                // empty current slot on a plain lookup: fall back one slot
                if (i_st.rd_empty && i_st.op != mrht_pkg::OP_HISTORY) begin
                    n_state = S_RD2;
                end else begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = mrht_pkg::RC_OK;
                    o_cmd.res_src  = mrht_pkg::SRC_MEM;
                    n_state        = S_OUT;
                end
            end
            S_RD2: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.rd_prev  = 1'b1;
                n_state        = S_RDW2;
            end
            S_RDW2: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_code = mrht_pkg::RC_OK;
                o_cmd.res_src  = mrht_pkg::SRC_MEM;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_push = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/mrht_dpath.sv =====
// ----------------------------------------------------------------------------
// mrht_dpath
// Node table, slot memories, restoring divider, configuration and result
// registers.
// ----------------------------------------------------------------------------
module mrht_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [mrht_pkg::INTERVAL_W-1:0]    i_cfg_wdata,
    input  logic [2:0]                         i_opcode,
    input  logic [15:0]                        i_node_addr,
    input  logic [55:0]                        i_node_mac,
    input  logic [31:0]                        i_reading_value,
    input  logic [7:0]                         i_reading_unit,
    input  logic [7:0]                         i_reading_status,
    input  logic [31:0]                        i_age_seconds,
    input  mrht_pkg::t_cmd                     i_cmd,
    output mrht_pkg::t_status                  o_st,
    output logic [2:0]                         o_result_code,
    output logic [4:0]                         o_entry_index,
    output logic [31:0]                        o_out_value,
    output logic [7:0]                         o_out_unit,
    output logic [7:0]                         o_out_status
);

    localparam int NW  = mrht_pkg::NODE_W;
    localparam int SW  = mrht_pkg::SLOT_W;
    localparam int AW  = mrht_pkg::MEM_AW;
    localparam int CW  = mrht_pkg::CNT_W;
    localparam int DW  = mrht_pkg::DVS_W;

    // configuration
    logic [mrht_pkg::INTERVAL_W-1:0] r_interval;
    logic                            r_gate;

    // captured item
    logic [2:0]  r_op;
    logic [15:0] r_addr;
    logic [55:0] r_mac;
    logic [31:0] r_val;
    logic [7:0]  r_unit;
    logic [7:0]  r_stat;

    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_cur;
    logic [NW-1:0] r_node;

    // node table
    logic [15:0] r_entry_addr [mrht_pkg::NODE_DEPTH];
    logic [55:0] r_entry_mac  [mrht_pkg::NODE_DEPTH];

    logic          r_found_addr, r_found_mac, r_found_free;
    logic [NW-1:0] r_addr_idx, r_mac_idx, r_free_idx;

    // divider
    logic [DW-1:0] r_dvs;
    logic [DW-1:0] r_rem;
    logic [31:0]   r_quo;

    // slot memories
    logic [31:0] mem_val [mrht_pkg::MEM_DEPTH];
    logic [15:0] mem_us  [mrht_pkg::MEM_DEPTH];
    logic [31:0] r_rd_val;
    logic [15:0] r_rd_us;

    // pending result
    logic [2:0]  r_res_code;
    logic [4:0]  r_res_idx;
    logic [31:0] r_res_val;
    logic [7:0]  r_res_unit;
    logic [7:0]  r_res_stat;

    logic [2:0]  r_out_code;
    logic [4:0]  r_out_idx;
    logic [31:0] r_out_val;
    logic [7:0]  r_out_unit;
    logic [7:0]  r_out_stat;

    logic [NW-1:0]        scan_idx;
    logic [15:0]          scan_addr;
    logic [SW-1:0]        cur_next;
    logic [SW-1:0]        cur_prev;
    logic [SW-1:0]        hist_slot;
    logic [SW-1:0]        n_slots;
    logic [SW:0]          hist_wide;
    logic [mrht_pkg::INTERVAL_W-1:0] iv;
    logic [DW:0]          div_t;
    logic [DW:0]          div_d;
    logic                 div_ge;
    logic [SW-1:0]        rd_slot;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [31:0]          wr_val;
    logic                 wr_val_en;
    logic                 wr_us_en;
    logic [NW-1:0]        node_pick;

    assign scan_idx  = r_cnt[NW-1:0];
    assign scan_addr = r_entry_addr[scan_idx];

    assign cur_next  = (r_cur == SW'(mrht_pkg::SLOT_DEPTH - 1)) ? '0 : r_cur + 1'b1;
    assign cur_prev  = (r_cur == '0) ? SW'(mrht_pkg::SLOT_DEPTH - 1) : r_cur - 1'b1;
    assign n_slots   = r_quo[SW-1:0];
    assign hist_wide = (r_cur >= n_slots) ? {1'b0, r_cur} - {1'b0, n_slots}
                     : {1'b0, r_cur} + (SW+1)'(mrht_pkg::SLOT_DEPTH) - {1'b0, n_slots};
    assign hist_slot = hist_wide[SW-1:0];

    assign iv    = (r_interval == '0) ? mrht_pkg::INTERVAL_W'(1) : r_interval;
    assign div_t = {r_rem, r_quo[31]};
    assign div_d = {1'b0, r_dvs};
    assign div_ge = (div_t >= div_d);

    always_comb begin
        priority if (i_cmd.rd_prev) begin
            rd_slot = cur_prev;
        end else if (r_op == mrht_pkg::OP_HISTORY) begin
            rd_slot = hist_slot;
        end else begin
            rd_slot = r_cur;
        end
    end
    assign rd_addr = {r_node, rd_slot};

    always_comb begin
        wr_addr   = {r_node, r_cur};
        wr_val    = r_val;
        wr_val_en = 1'b0;
        wr_us_en  = 1'b0;
        priority if (i_cmd.clear_wr) begin
            wr_addr   = r_cnt[AW-1:0];
            wr_val    = mrht_pkg::EMPTY_VALUE;
            wr_val_en = 1'b1;
            wr_us_en  = 1'b1;
        end else if (i_cmd.tick_wr) begin
            wr_addr   = {scan_idx, r_cur};
            wr_val    = mrht_pkg::EMPTY_VALUE;
            wr_val_en = 1'b1;
        end else if (i_cmd.rep_wr) begin
            wr_val_en = 1'b1;
            wr_us_en  = 1'b1;
        end else begin
            wr_val_en = 1'b0;
        end
    end

    always_comb begin
        unique case (r_op)
            mrht_pkg::OP_REPORT:   node_pick = r_found_addr ? r_addr_idx : r_free_idx;
            mrht_pkg::OP_READ_MAC: node_pick = r_mac_idx;
            default:               node_pick = r_addr_idx;
        endcase
    end

    // configuration and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= mrht_pkg::INTERVAL_W'(5);
            r_gate     <= 1'b1;
            r_cnt      <= '0;
            r_cur      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mrht_pkg::REG_INTERVAL: r_interval <= i_cfg_wdata;
                    mrht_pkg::REG_GATE:     r_gate     <= i_cfg_wdata[0];
                    default:                r_gate     <= r_gate;
                endcase
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.tick_adv) begin
                r_cur <= cur_next;
            end
        end
    end

    // node table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mrht_pkg::NODE_DEPTH; i++) begin
                r_entry_addr[i] <= '0;
            end
        end else if (i_cmd.rep_wr) begin
            r_entry_addr[r_node] <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rep_wr) begin
            r_entry_mac[r_node] <= r_mac;
        end
    end

    // capture, scan, divide, results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= i_opcode;
            r_addr       <= i_node_addr;
            r_mac        <= i_node_mac;
            r_val        <= i_reading_value;
            r_unit       <= i_reading_unit;
            r_stat       <= i_reading_status;
            r_quo        <= i_age_seconds;
            r_rem        <= '0;
            r_dvs        <= DW'(iv) * DW'(mrht_pkg::SEC_PER_MIN);
            r_found_addr <= 1'b0;
            r_found_mac  <= 1'b0;
            r_found_free <= 1'b0;
        end
        if (i_cmd.scan) begin
            // keep the lowest match of each kind
            if (!r_found_addr && r_addr != '0 && scan_addr == r_addr) begin
                r_found_addr <= 1'b1;
                r_addr_idx   <= scan_idx;
            end
            if (!r_found_mac && scan_addr != '0 && r_entry_mac[scan_idx] == r_mac) begin
                r_found_mac <= 1'b1;
                r_mac_idx   <= scan_idx;
            end
            if (!r_found_free && scan_addr == '0) begin
                r_found_free <= 1'b1;
                r_free_idx   <= scan_idx;
            end
        end
        if (i_cmd.node_set) begin
            r_node <= node_pick;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? DW'(div_t - div_d) : div_t[DW-1:0];
            r_quo <= {r_quo[30:0], div_ge};
        end
        if (i_cmd.res_load) begin
            r_res_code <= i_cmd.res_code;
            unique case (i_cmd.res_src)
                mrht_pkg::SRC_NONE: begin
                    r_res_idx  <= '0;
                    r_res_val  <= '0;
                    r_res_unit <= '0;
                    r_res_stat <= '0;
                end
                mrht_pkg::SRC_IDX: begin
                    r_res_idx  <= 5'(r_node);
                    r_res_val  <= '0;
                    r_res_unit <= '0;
                    r_res_stat <= '0;
                end
                mrht_pkg::SRC_MEM: begin
                    r_res_idx  <= 5'(r_node);
                    r_res_val  <= r_rd_val;
                    r_res_unit <= r_rd_us[15:8];
                    r_res_stat <= r_rd_us[7:0];
                end
                default: begin
                    r_res_idx  <= 5'(r_node);
                    r_res_val  <= r_val;
                    r_res_unit <= r_unit;
                    r_res_stat <= r_stat;
                end
            endcase
        end
        if (i_cmd.out_push) begin
            r_out_code <= r_res_code;
            r_out_idx  <= r_res_idx;
            r_out_val  <= r_res_val;
            r_out_unit <= r_res_unit;
            r_out_stat <= r_res_stat;
        end
    end

    // slot memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_val_en) begin
            mem_val[wr_addr] <= wr_val;
        end
        if (wr_us_en) begin
            mem_us[wr_addr] <= i_cmd.clear_wr ? 16'hFFFF : {r_unit, r_stat};
        end
        if (i_cmd.rd_issue) begin
            r_rd_val <= mem_val[rd_addr];
            r_rd_us  <= mem_us[rd_addr];
        end
    end

    assign o_st.op         = r_op;
    assign o_st.gate       = r_gate;
    assign o_st.addr_zero  = (r_addr == '0);
    assign o_st.clr_last   = (r_cnt[AW-1:0] == {AW{1'b1}});
    assign o_st.scan_last  = (scan_idx == NW'(mrht_pkg::NODE_DEPTH - 1));
    assign o_st.div_last   = (r_cnt[4:0] == 5'd31);
    assign o_st.found_addr = r_found_addr;
    assign o_st.found_mac  = r_found_mac;
    assign o_st.found_free = r_found_free;
    assign o_st.too_old    = (r_quo >= 32'(mrht_pkg::SLOT_DEPTH));
    assign o_st.rd_empty   = (r_rd_val == mrht_pkg::EMPTY_VALUE);

    assign o_result_code = r_out_code;
    assign o_entry_index = r_out_idx;
    assign o_out_value   = r_out_val;
    assign o_out_unit    = r_out_unit;
    assign o_out_status  = r_out_stat;

endmodule
